// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ARPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ARPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/arpc_pkg.sv =====
// Shared types and constants of the ARP responder and address cache.
// No dependencies.
package arpc_pkg;

  localparam int CACHE_DEPTH_DEF = 64;
  localparam int SLOT_W          = 6;
  localparam int CNT_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 48;

  localparam logic [10:0] ARP_MIN_LEN = 11'd42;
  localparam logic [15:0] HTYPE_ETH   = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  HLEN_ETH    = 8'd6;
  localparam logic [7:0]  PLEN_IPV4   = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [15:0] OP_REPLY    = 16'h0002;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] operation;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
    logic [5:0]  entry_index;
  } arpc_in_t;

  typedef struct packed {
    logic              reply_send;
    logic [47:0]       reply_target_mac;
    logic [31:0]       reply_target_ip;
    logic              learned;
    logic              dropped_full;
    logic              hit;
    logic [47:0]       entry_mac;
    logic [31:0]       entry_ip;
    logic [SLOT_W-1:0] found_index;
    logic [CNT_W-1:0]  entry_count;
  } arpc_out_t;

  // Search word that travels down the row of cache cells.
  typedef struct packed {
    logic              vld;
    logic              is_read;
    logic              hit;
    logic [31:0]       query_ip;
    logic [SLOT_W-1:0] read_idx;
    logic [47:0]       mac;
    logic [31:0]       ip;
    logic [SLOT_W-1:0] fidx;
  } arpc_tok_t;

  // Append request broadcast to the cells.
  typedef struct packed {
    logic        en;
    logic [47:0] mac;
    logic [31:0] ip;
  } arpc_wr_t;

endpackage

// ===== hdl/arpc_cell.sv =====
// One cache slot: holds one MAC/IP pair and passes the search word on.
// Depends on arpc_pkg.
module arpc_cell
  import arpc_pkg::*;
#(
  parameter int SLOT = 0,
  parameter int CW   = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] fill_count,
  input  arpc_wr_t      wr,
  input  arpc_tok_t     tok_in,
  output arpc_tok_t     tok_out
);

  localparam int          SLOT_U    = SLOT;
  localparam logic        IDX_REACH = (SLOT < (1 << SLOT_W));
  localparam logic [SLOT_W-1:0] SLOT_IDX = SLOT_U[SLOT_W-1:0];

  logic [47:0] mac_r;
  logic [31:0] ip_r;
  arpc_tok_t   tok_r;
  arpc_tok_t   tok_nxt;
  logic        live;
  logic        match;

  assign live = (fill_count > CW'(SLOT));

  always_comb begin
    match = 1'b0;
    if (tok_in.vld && !tok_in.hit && live) begin
      if (tok_in.is_read) begin
        match = IDX_REACH && (tok_in.read_idx == SLOT_IDX);
      end else begin
        match = (ip_r == tok_in.query_ip);
      end
    end
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.mac  = mac_r;
      tok_nxt.ip   = ip_r;
      tok_nxt.fidx = SLOT_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (fill_count == CW'(SLOT))) begin
      mac_r <= wr.mac;
      ip_r  <= wr.ip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hdl/arpc_ctrl.sv =====
// Sequencer: configuration registers, frame checks, fill count, search
// launch and the result register. Depends on arpc_pkg.
module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
  parameter int CW          = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arpc_in_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output arpc_out_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [CW-1:0]         fill_count,
  output arpc_wr_t              wr,
  output arpc_tok_t             tok_head,
  input  arpc_tok_t             tok_tail
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic [47:0]   own_mac_r;
  logic [31:0]   own_ip_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          out_valid_r, out_valid_nxt;
  arpc_out_t     out_r, out_nxt;
  logic          acc;
  logic          is_frame, is_search;
  logic          frame_ok, learn, full;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign is_frame  = (in_word.kind == KIND_FRAME);
  assign is_search = (in_word.kind == KIND_LOOKUP) || (in_word.kind == KIND_READ);
  assign full      = (fill_r == CW'(CACHE_DEPTH));

  assign frame_ok = (in_word.frame_length >= ARP_MIN_LEN)
                 && (in_word.hw_type == HTYPE_ETH)
                 && (in_word.proto_type == PTYPE_IPV4)
                 && (in_word.hw_len == HLEN_ETH)
                 && (in_word.proto_len == PLEN_IPV4)
                 && (in_word.target_ip == own_ip_r);

  assign learn = acc && is_frame && frame_ok && (in_word.operation == OP_REPLY) && !full;

  assign wr.en  = learn;
  assign wr.mac = in_word.sender_mac;
  assign wr.ip  = in_word.sender_ip;

  always_comb begin
    tok_head          = '0;
    tok_head.vld      = acc && is_search;
    tok_head.is_read  = (in_word.kind == KIND_READ);
    tok_head.query_ip = in_word.query_ip;
    tok_head.read_idx = in_word.entry_index;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (learn) begin
      fill_nxt = fill_r + CW'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (is_search) begin
            state_nxt = ST_SCAN;
          end else begin
            out_nxt             = '0;
            out_valid_nxt       = 1'b1;
            out_nxt.entry_count = CNT_W'(fill_nxt);
            if (is_frame && frame_ok) begin
              if (in_word.operation == OP_REQUEST) begin
                out_nxt.reply_send       = 1'b1;
                out_nxt.reply_target_mac = in_word.sender_mac;
                out_nxt.reply_target_ip  = in_word.sender_ip;
              end else if (in_word.operation == OP_REPLY) begin
                out_nxt.learned      = !full;
                out_nxt.dropped_full = full;
              end
            end
          end
        end
      end
      ST_SCAN: begin
        if (tok_tail.vld) begin
          state_nxt           = ST_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.hit         = tok_tail.hit;
          out_nxt.entry_mac   = tok_tail.mac;
          out_nxt.entry_ip    = tok_tail.ip;
          out_nxt.found_index = tok_tail.fidx;
          out_nxt.entry_count = CNT_W'(fill_r);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      own_mac_r   <= '0;
      own_ip_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OWN_MAC) begin
          own_mac_r <= cfg_data[47:0];
        end else if (cfg_index == CFG_OWN_IP) begin
          own_ip_r <= cfg_data[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_r;
  assign fill_count = fill_r;

endmodule

// ===== hdl/arp_responder_and_cache.sv =====
// Top level of the ARP responder with address cache: sequencer plus a row
// of cache cells. Depends on arpc_pkg, arpc_ctrl and arpc_cell.
//
//   channel  signals                     direction  role
//   in       in_valid/in_ready/in_word   input      frames, lookups, reads
//   out      out_valid/out_ready/out_word output    one result per item
//   cfg      cfg_valid/cfg_ready/cfg_*   input      own_mac, own_ip writes
//
// Frames and unused kinds give their result in the cycle after acceptance.
// Lookups and reads send the search word down the row of CACHE_DEPTH cells,
// one cell per cycle, to be caught at the end. The next item is taken once
// no search is in flight and the result register is free or being read.
// Reset is synchronous and clears the fill count; there is no clearing pass.
// A stalled output holds its word and blocks further input.
module arp_responder_and_cache
  import arpc_pkg::*;
#(
  parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arpc_in_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output arpc_out_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(CACHE_DEPTH + 1);

  logic [CW-1:0] fill_count;
  arpc_wr_t      wr;
  arpc_tok_t     tok [0:CACHE_DEPTH];

  arpc_ctrl #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fill_count (fill_count),
    .wr         (wr),
    .tok_head   (tok[0]),
    .tok_tail   (tok[CACHE_DEPTH])
  );

  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    arpc_cell #(
      .SLOT (i),
      .CW   (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .fill_count (fill_count),
      .wr         (wr),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

endmodule

// ===== hdl/arpc_checker.sv =====
// Port-level checks on the ARP responder with address cache, bound to the
// top level. Depends on arpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arpc_checker
  import arpc_pkg::*;
#(
  parameter int DEPTH = CACHE_DEPTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input arpc_out_t             out_word
);

  localparam int         FULL_INT = DEPTH % 128;
  localparam logic [6:0] FULL_CNT = FULL_INT[6:0];

  `ARPC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word), "result word changed while stalled")
  `ARPC_ASSERT(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready |-> !in_ready, "input taken while a result is stalled")
  `ARPC_ASSERT(a_one_action, clk, rst_n, out_valid |-> $countones({out_word.reply_send, out_word.learned, out_word.dropped_full, out_word.hit}) <= 1, "result reports more than one action")
  `ARPC_ASSERT(a_drop_when_full, clk, rst_n, out_valid && out_word.dropped_full |-> out_word.entry_count == FULL_CNT, "drop reported below full count")

endmodule

bind arp_responder_and_cache arpc_checker #(.DEPTH(CACHE_DEPTH)) u_arpc_checker (.*);
